@@ hdl/lex_pkg.sv @@
package lex_pkg;

    localparam int MAX_WORDS  = 512;
    localparam int MAX_BITS   = 25;
    localparam int ADDR_W     = $clog2(MAX_WORDS);
    localparam int CNT_W      = ADDR_W + 1;
    localparam int DIST_W     = $clog2(MAX_BITS + 1);
    localparam int T_W        = 3;
    localparam int DMIN_W     = T_W + 1;
    localparam int OP_W       = 2;
    localparam int STATUS_W   = 4;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 10;

    // popcount split into small groups, then a short sum over the groups
    localparam int GRP    = 5;
    localparam int NGRP   = (MAX_BITS + GRP - 1) / GRP;
    localparam int PAD_W  = NGRP * GRP;
    localparam int GRP_W  = $clog2(GRP + 1);

    localparam logic [OP_W-1:0] OP_BUILD  = 2'd0;
    localparam logic [OP_W-1:0] OP_ENCODE = 2'd1;
    localparam logic [OP_W-1:0] OP_DECODE = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_WORD_COUNT    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CORRECT_COUNT = 2'd1;

    localparam logic [STATUS_W-1:0] ST_VALID         = 4'd0;
    localparam logic [STATUS_W-1:0] ST_CORRECTED     = 4'd1;
    localparam logic [STATUS_W-1:0] ST_AMBIGUOUS     = 4'd2;
    localparam logic [STATUS_W-1:0] ST_DETECTED      = 4'd3;
    localparam logic [STATUS_W-1:0] ST_UNCORRECTABLE = 4'd4;
    localparam logic [STATUS_W-1:0] ST_BUILT         = 4'd5;
    localparam logic [STATUS_W-1:0] ST_BUILD_FAILED  = 4'd6;
    localparam logic [STATUS_W-1:0] ST_ENCODED       = 4'd7;
    localparam logic [STATUS_W-1:0] ST_NOT_BUILT     = 4'd8;
    localparam logic [STATUS_W-1:0] ST_OUT_OF_RANGE  = 4'd9;

    localparam logic [CNT_W-1:0] WC_RESET = CNT_W'(2);
    localparam logic [T_W-1:0]   T_RESET  = T_W'(1);

    // low len bits set
    function automatic logic [MAX_BITS-1:0] low_mask(input logic [DIST_W-1:0] len);
        logic [MAX_BITS-1:0] m;
        for (int k = 0; k < MAX_BITS; k++)
        begin
            m[k] = (DIST_W'(k) < len);
        end
        return m;
    endfunction

endpackage

@@ hdl/lex_ram.sv @@
module lex_ram (
    input  logic                          clk,
    input  logic                          we,
    input  logic [lex_pkg::ADDR_W-1:0]    addr,
    input  logic [lex_pkg::MAX_BITS-1:0]  wdata,
    output logic [lex_pkg::MAX_BITS-1:0]  rdata
);

    logic [lex_pkg::MAX_BITS-1:0] mem [lex_pkg::MAX_WORDS];
    logic [lex_pkg::MAX_BITS-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata_reg <= mem[addr];
    end

    assign rdata = rdata_reg;

endmodule

@@ hdl/lex_dist.sv @@
module lex_dist (
    input  logic [lex_pkg::MAX_BITS-1:0] a,
    input  logic [lex_pkg::MAX_BITS-1:0] b,
    output logic [lex_pkg::DIST_W-1:0]   ham_dist
);

    logic [lex_pkg::PAD_W-1:0]  x;
    logic [lex_pkg::GRP_W-1:0]  grp_cnt [lex_pkg::NGRP];
    logic [lex_pkg::DIST_W-1:0] total;

    always_comb
    begin
        x = '0;
        x[lex_pkg::MAX_BITS-1:0] = a ^ b;
        for (int g = 0; g < lex_pkg::NGRP; g++)
        begin
            grp_cnt[g] = '0;
            for (int k = 0; k < lex_pkg::GRP; k++)
            begin
                grp_cnt[g] = grp_cnt[g] + lex_pkg::GRP_W'(x[g * lex_pkg::GRP + k]);
            end
        end
        total = '0;
        for (int g = 0; g < lex_pkg::NGRP; g++)
        begin
            total = total + lex_pkg::DIST_W'(grp_cnt[g]);
        end
    end

    assign ham_dist = total;

endmodule

@@ hdl/lexicode_build_and_nearest_decode.sv @@
// greedy lexicode builder and nearest-codeword decoder
// command channel: cmd_valid/cmd_stall with opcode, data_value, received_word;
//   a request is taken when cmd_valid is high and cmd_stall low, and only one
//   request is in work at a time (cmd_stall is high until it is finished)
// result channel: res_valid/res_stall with status, data_index, codeword,
//   error_distance, length_bits; one result per request, opcode 3 gives none
// config channel: cfg_valid/cfg_ready, cfg_index 0 word_count, 1 correct_count;
//   either write clears the built flag; a pending config write goes before a
//   request offered in the same cycle (cmd_stall is high while cfg_valid is)
// encode reads its codeword from the ram in S_ENC, and early refusals go straight
//   to S_FINISH; decode runs one codebook read and one distance compare per cycle
//   through the single ram port and the shared distance unit, over word_count
//   entries; build runs one compare per cycle against the kept words for every
//   candidate word
// the result sits in an output register; a new request is taken while it waits,
//   but that request's result is held back until the receiver drops res_stall
// reset: word_count 2, correct_count 1, no codebook built; the codebook ram has
//   no reset and is read only at entries a build has written
module lexicode_build_and_nearest_decode (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [lex_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [lex_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  logic                              cmd_valid,
    output logic                              cmd_stall,
    input  logic [1:0]                        opcode,
    input  logic [8:0]                        data_value,
    input  logic [24:0]                       received_word,
    output logic                              res_valid,
    input  logic                              res_stall,
    output logic [3:0]                        status,
    output logic [8:0]                        data_index,
    output logic [24:0]                       codeword,
    output logic [4:0]                        error_distance,
    output logic [4:0]                        length_bits
);

    typedef enum logic [6:0] {
        S_IDLE   = 7'b0000001,
        S_BINIT  = 7'b0000010,
        S_BSCAN  = 7'b0000100,
        S_BWRITE = 7'b0001000,
        S_ENC    = 7'b0010000,
        S_DSCAN  = 7'b0100000,
        S_FINISH = 7'b1000000
    } state_t;

    localparam int AW = lex_pkg::ADDR_W;
    localparam int CW = lex_pkg::CNT_W;
    localparam int BW = lex_pkg::MAX_BITS;
    localparam int DW = lex_pkg::DIST_W;
    localparam int SW = lex_pkg::STATUS_W;

    state_t             state_reg, state_next;
    logic [CW-1:0]      wc_reg, wc_next;
    logic [2:0]         t_reg, t_next;
    logic               built_reg, built_next;
    logic [DW-1:0]      len_reg, len_next;
    logic [BW-1:0]      key_reg, key_next;
    logic [DW-1:0]      wlen_reg, wlen_next;
    logic [CW-1:0]      count_reg, count_next;
    logic [CW-1:0]      i_reg, i_next;
    logic               pv_reg, pv_next;
    logic [AW-1:0]      ev_idx_reg, ev_idx_next;
    logic [DW-1:0]      best_reg, best_next;
    logic [AW-1:0]      best_idx_reg, best_idx_next;
    logic               ambig_reg, ambig_next;
    logic               out_valid_reg, out_valid_next;

    logic [SW-1:0]      p_status_reg, p_status_next;
    logic [AW-1:0]      p_index_reg, p_index_next;
    logic [BW-1:0]      p_cw_reg, p_cw_next;
    logic [DW-1:0]      p_dist_reg, p_dist_next;
    logic [DW-1:0]      p_len_reg, p_len_next;

    logic [SW-1:0]      o_status_reg;
    logic [AW-1:0]      o_index_reg;
    logic [BW-1:0]      o_cw_reg;
    logic [DW-1:0]      o_dist_reg;
    logic [DW-1:0]      o_len_reg;

    logic               ram_we;
    logic [AW-1:0]      ram_addr;
    logic [BW-1:0]      ram_wdata;
    logic [BW-1:0]      ram_rdata;
    logic [DW-1:0]      ham_dist;

    logic               cmd_take;
    logic               cfg_take;
    logic               load;
    logic [lex_pkg::DMIN_W-1:0] dmin;
    logic [BW-1:0]      key_inc;
    logic               key_pow2;
    logic               key_max;
    logic [CW-1:0]      count_inc;

    lex_ram u_ram (
        .clk   (clk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    lex_dist u_dist (
        .a        (key_reg),
        .b        (ram_rdata),
        .ham_dist (ham_dist)
    );

    assign cmd_stall = (state_reg != S_IDLE) || cfg_valid;
    assign cfg_ready = (state_reg == S_IDLE);
    assign cmd_take  = cmd_valid && !cmd_stall;
    assign cfg_take  = cfg_valid && cfg_ready;
    assign load      = (state_reg == S_FINISH) && (!out_valid_reg || !res_stall);

    // t of zero means detect only at distance two
    assign dmin      = (t_reg == '0) ? lex_pkg::DMIN_W'(2) : {t_reg, 1'b1};
    assign key_inc   = key_reg + BW'(1);
    assign key_pow2  = ((key_inc & key_reg) == '0);
    assign key_max   = &key_reg;
    assign count_inc = count_reg + CW'(1);

    always_comb
    begin
        ram_we    = 1'b0;
        ram_addr  = i_reg[AW-1:0];
        ram_wdata = key_reg;
        case (state_reg)
            S_IDLE:
            begin
                ram_addr = data_value;
            end
            S_BINIT:
            begin
                ram_we    = 1'b1;
                ram_addr  = '0;
                ram_wdata = '0;
            end
            S_BWRITE:
            begin
                ram_we   = 1'b1;
                ram_addr = count_reg[AW-1:0];
            end
            default:
            begin
                ram_addr = i_reg[AW-1:0];
            end
        endcase
    end

    always_comb
    begin
        state_next    = state_reg;
        wc_next       = wc_reg;
        t_next        = t_reg;
        built_next    = built_reg;
        len_next      = len_reg;
        key_next      = key_reg;
        wlen_next     = wlen_reg;
        count_next    = count_reg;
        i_next        = i_reg;
        pv_next       = pv_reg;
        ev_idx_next   = ev_idx_reg;
        best_next     = best_reg;
        best_idx_next = best_idx_reg;
        ambig_next    = ambig_reg;
        p_status_next = p_status_reg;
        p_index_next  = p_index_reg;
        p_cw_next     = p_cw_reg;
        p_dist_next   = p_dist_reg;
        p_len_next    = p_len_reg;

        out_valid_next = out_valid_reg && res_stall;
        if (load)
        begin
            out_valid_next = 1'b1;
        end

        if (cfg_take)
        begin
            case (cfg_index)
                lex_pkg::CFG_WORD_COUNT:
                begin
                    wc_next    = cfg_data[CW-1:0];
                    built_next = 1'b0;
                end
                lex_pkg::CFG_CORRECT_COUNT:
                begin
                    t_next     = cfg_data[2:0];
                    built_next = 1'b0;
                end
                default:
                begin
                    wc_next = wc_reg;
                end
            endcase
        end

        case (state_reg)
            S_IDLE:
            begin
                if (cmd_take)
                begin
                    p_status_next = lex_pkg::ST_NOT_BUILT;
                    p_index_next  = '0;
                    p_cw_next     = '0;
                    p_dist_next   = '0;
                    p_len_next    = '0;
                    i_next        = '0;
                    pv_next       = 1'b0;
                    case (opcode)
                        lex_pkg::OP_BUILD:
                        begin
                            built_next = 1'b0;
                            len_next   = '0;
                            key_next   = BW'(1);
                            wlen_next  = DW'(1);
                            count_next = CW'(1);
                            if (wc_reg < CW'(2) || wc_reg > CW'(lex_pkg::MAX_WORDS))
                            begin
                                p_status_next = lex_pkg::ST_BUILD_FAILED;
                                state_next    = S_FINISH;
                            end
                            else
                            begin
                                state_next = S_BINIT;
                            end
                        end
                        lex_pkg::OP_ENCODE:
                        begin
                            if (!built_reg)
                            begin
                                state_next = S_FINISH;
                            end
                            else if (CW'(data_value) >= wc_reg)
                            begin
                                p_status_next = lex_pkg::ST_OUT_OF_RANGE;
                                state_next    = S_FINISH;
                            end
                            else
                            begin
                                state_next = S_ENC;
                            end
                        end
                        lex_pkg::OP_DECODE:
                        begin
                            key_next   = received_word & lex_pkg::low_mask(len_reg);
                            best_next  = '1;
                            ambig_next = 1'b0;
                            state_next = built_reg ? S_DSCAN : S_FINISH;
                        end
                        default:
                        begin
                            // unused opcode: taken, no result
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end

            S_BINIT:
            begin
                state_next = S_BSCAN;
            end

            S_BSCAN:
            begin
                if (pv_reg && (ham_dist < DW'(dmin)))
                begin
                    // candidate too close to a kept word, move on
                    pv_next = 1'b0;
                    i_next  = '0;
                    if (key_max)
                    begin
                        p_status_next = lex_pkg::ST_BUILD_FAILED;
                        state_next    = S_FINISH;
                    end
                    else
                    begin
                        key_next  = key_inc;
                        wlen_next = wlen_reg + DW'(key_pow2);
                    end
                end
                else if (i_reg < count_reg)
                begin
                    i_next  = i_reg + CW'(1);
                    pv_next = 1'b1;
                end
                else
                begin
                    pv_next = 1'b0;
                    if (!pv_reg)
                    begin
                        state_next = S_BWRITE;
                    end
                end
            end

            S_BWRITE:
            begin
                count_next = count_inc;
                i_next     = '0;
                pv_next    = 1'b0;
                if (count_inc == wc_reg)
                begin
                    // codewords rise, so the last one sets the length
                    built_next    = 1'b1;
                    len_next      = wlen_reg;
                    p_status_next = lex_pkg::ST_BUILT;
                    p_len_next    = wlen_reg;
                    state_next    = S_FINISH;
                end
                else if (key_max)
                begin
                    p_status_next = lex_pkg::ST_BUILD_FAILED;
                    state_next    = S_FINISH;
                end
                else
                begin
                    key_next   = key_inc;
                    wlen_next  = wlen_reg + DW'(key_pow2);
                    state_next = S_BSCAN;
                end
            end

            S_ENC:
            begin
                p_status_next = lex_pkg::ST_ENCODED;
                p_cw_next     = ram_rdata;
                state_next    = S_FINISH;
            end

            S_DSCAN:
            begin
                if (pv_reg)
                begin
                    if (ev_idx_reg == '0 || ham_dist < best_reg)
                    begin
                        best_next     = ham_dist;
                        best_idx_next = ev_idx_reg;
                        ambig_next    = 1'b0;
                    end
                    else if (ham_dist == best_reg)
                    begin
                        ambig_next = 1'b1;
                    end
                end
                if (i_reg < wc_reg)
                begin
                    ev_idx_next = i_reg[AW-1:0];
                    i_next      = i_reg + CW'(1);
                    pv_next     = 1'b1;
                end
                else
                begin
                    pv_next = 1'b0;
                    if (!pv_reg)
                    begin
                        state_next = S_FINISH;
                        if (best_reg == '0)
                        begin
                            p_status_next = lex_pkg::ST_VALID;
                            p_index_next  = best_idx_reg;
                        end
                        else
                        begin
                            p_dist_next = best_reg;
                            if (ambig_reg)
                            begin
                                p_status_next = lex_pkg::ST_AMBIGUOUS;
                            end
                            else if (t_reg == '0)
                            begin
                                p_status_next = lex_pkg::ST_DETECTED;
                            end
                            else if (best_reg <= DW'(t_reg))
                            begin
                                p_status_next = lex_pkg::ST_CORRECTED;
                                p_index_next  = best_idx_reg;
                            end
                            else
                            begin
                                p_status_next = lex_pkg::ST_UNCORRECTABLE;
                            end
                        end
                    end
                end
            end

            S_FINISH:
            begin
                if (load)
                begin
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            wc_reg        <= lex_pkg::WC_RESET;
            t_reg         <= lex_pkg::T_RESET;
            built_reg     <= 1'b0;
            len_reg       <= '0;
            count_reg     <= '0;
            i_reg         <= '0;
            pv_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            wc_reg        <= wc_next;
            t_reg         <= t_next;
            built_reg     <= built_next;
            len_reg       <= len_next;
            count_reg     <= count_next;
            i_reg         <= i_next;
            pv_reg        <= pv_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg      <= key_next;
        wlen_reg     <= wlen_next;
        ev_idx_reg   <= ev_idx_next;
        best_reg     <= best_next;
        best_idx_reg <= best_idx_next;
        ambig_reg    <= ambig_next;
        p_status_reg <= p_status_next;
        p_index_reg  <= p_index_next;
        p_cw_reg     <= p_cw_next;
        p_dist_reg   <= p_dist_next;
        p_len_reg    <= p_len_next;
        if (load)
        begin
            o_status_reg <= p_status_reg;
            o_index_reg  <= p_index_reg;
            o_cw_reg     <= p_cw_reg;
            o_dist_reg   <= p_dist_reg;
            o_len_reg    <= p_len_reg;
        end
    end

    assign res_valid      = out_valid_reg;
    assign status         = o_status_reg;
    assign data_index     = o_index_reg;
    assign codeword       = o_cw_reg;
    assign error_distance = o_dist_reg;
    assign length_bits    = o_len_reg;

endmodule
